// ----- rtl/wmsb_pkg.sv -----
// package for the windowed mean / standard deviation band block
// constants shared by the channel interfaces and the rtl modules
// no dependencies
`default_nettype none

package wmsb_pkg;

    // window register and sample counters
    localparam int CNT_W           = 7;
    localparam int WIN_RESET       = 8;
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    // fixed point format of the results
    localparam int FRAC_W = 8;
    localparam int MEAN_W = 24;
    localparam int BAND_W = 25;

    // band margin is sigma * 49 / 25 (1.96 exactly)
    localparam int MARGIN_NUM = 49;
    localparam int MARGIN_DEN = 25;
    localparam int MARGIN_W   = 6;

    // saturation limits
    localparam int MEAN_MAX = 2**MEAN_W - 1;
    localparam int HIGH_MAX = 2**BAND_W - 1;
    localparam int LOW_MAX  = 2**(BAND_W - 1) - 1;
    localparam int LOW_MIN  = -(2**(BAND_W - 1));

endpackage

`default_nettype wire

// ----- rtl/wmsb_if.sv -----
// valid/ready channel interfaces: sample request, result request, window write
// depends on wmsb_pkg
`default_nettype none

interface wmsb_sample_if #(
    parameter int SAMPLE_BITS = wmsb_pkg::DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface wmsb_result_if;
    logic                                valid;
    logic                                ready;
    logic [wmsb_pkg::MEAN_W-1:0]         window_mean;
    logic signed [wmsb_pkg::BAND_W-1:0]  band_low;
    logic [wmsb_pkg::BAND_W-1:0]         band_high;
    logic [wmsb_pkg::CNT_W-1:0]          samples_used;

    modport source (output valid, output window_mean, output band_low,
                    output band_high, output samples_used, input ready);
    modport sink   (input valid, input window_mean, input band_low,
                    input band_high, input samples_used, output ready);
endinterface

interface wmsb_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [wmsb_pkg::CNT_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

// ----- rtl/wmsb_smul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on nothing outside this file
`default_nettype none

module wmsb_smul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [AW-1:0]    a,
    input  wire logic [BW-1:0]    b,
    output logic                  busy,
    output logic [AW+BW-1:0]      product
);

    localparam int CTW = $clog2(BW + 1);

    logic [CTW-1:0]   cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [AW-1:0]    a_reg;
    logic [AW+BW-1:0] p_reg, p_next;
    logic [AW:0]      hi_sum;

    // add the multiplicand into the high half, then shift right one bit
    always_comb
    begin
        hi_sum = {1'b0, p_reg[AW+BW-1:BW]} + (p_reg[0] ? {1'b0, a_reg} : '0);
        p_next = {hi_sum, p_reg[BW-1:1]};
    end

    // iteration control
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            cnt_next  = CTW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CTW'(1);
            if (cnt_reg == CTW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // operand and partial product shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {{AW{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
        end
    end

    assign busy    = busy_reg;
    assign product = p_reg;

endmodule

`default_nettype wire

// ----- rtl/wmsb_sdiv.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on nothing outside this file
`default_nettype none

module wmsb_sdiv #(
    parameter int NW = 31,
    parameter int DW = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               busy,
    output logic [NW-1:0]      quotient
);

    localparam int CTW = $clog2(NW + 1);

    logic [CTW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [NW-1:0]  q_reg;
    logic [DW-1:0]  r_reg;
    logic [DW-1:0]  d_reg;
    logic [DW:0]    shifted;
    logic [DW:0]    diff;
    logic           fits;

    // bring down the next dividend bit and try the subtraction
    always_comb
    begin
        shifted = {r_reg, q_reg[NW-1]};
        diff    = shifted - {1'b0, d_reg};
        fits    = (shifted >= {1'b0, d_reg});
    end

    // iteration control
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            cnt_next  = CTW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CTW'(1);
            if (cnt_reg == CTW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // dividend shifts out at the top while quotient bits shift in below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NW-2:0], fits};
            r_reg <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ----- rtl/wmsb_sqrt.sv -----
// digit-by-digit integer square root, one root bit (two radicand bits) per cycle
// depends on nothing outside this file
`default_nettype none

module wmsb_sqrt #(
    parameter int RW = 31
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [2*RW-1:0] radicand,
    output logic                 busy,
    output logic [RW-1:0]        root
);

    localparam int CTW = $clog2(RW + 1);

    logic [CTW-1:0]  cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [2*RW-1:0] rad_reg;
    logic [RW:0]     rem_reg;
    logic [RW-1:0]   root_reg;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            fits;

    // remainder takes two more radicand bits, trial is 4*root + 1
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[2*RW-1 -: 2]};
        trial  = (RW+3)'({root_reg, 2'b01});
        diff   = rem_sh - trial;
        fits   = (rem_sh >= trial);
    end

    // iteration control
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            cnt_next  = CTW'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CTW'(1);
            if (cnt_reg == CTW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // radicand shift register and partial root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
            rem_reg  <= fits ? diff[RW:0] : rem_sh[RW:0];
            root_reg <= {root_reg[RW-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- rtl/window_mean_stddev_band.sv -----
// top level: windowed mean and 1.96-sigma band over the most recent samples
// depends on wmsb_pkg, wmsb_if, wmsb_smul, wmsb_sdiv, wmsb_sqrt
//
// Channels: item carries one sample request (sample, restart), result carries
// one result request (window_mean, band_low, band_high, samples_used), cfg
// writes the window_size register and is always ready. A window write or a
// restart bit clears the history; the restarted sample is the first of the
// new window. All handshakes complete at a rising edge with valid and ready
// high.
// Steps: the ring read at accept, then the squares of the new and evicted
// samples (the squared sum runs alongside), then n times the square sum, then
// the root (with the mean divide), the sigma divide and the divide by 25. One
// sample is in work at a time, and the next request can be taken in the cycle
// after the result loads.
// A finished result sits in the output register; a new sample request is
// taken while it waits. If the receiver stalls, the next result holds in
// the last step until the output register frees up.
// Reset: window returns to 8, history is empty, no result is pending. The
// sample ring needs no clearing pass.
`default_nettype none

module window_mean_stddev_band #(
    parameter int MAX_WINDOW  = wmsb_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = wmsb_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    wmsb_sample_if.sink      item,
    wmsb_result_if.source    result,
    wmsb_cfg_if.sink         cfg
);

    localparam int CW      = wmsb_pkg::CNT_W;
    localparam int FW      = wmsb_pkg::FRAC_W;
    localparam int CAP     = (MAX_WINDOW > 2**CW - 1) ? 2**CW - 1 : MAX_WINDOW;
    localparam int DEPTH   = CAP;
    localparam int AW      = $clog2(DEPTH);
    localparam int SUM_W   = SAMPLE_BITS + CW;
    localparam int SQ_W    = 2*SAMPLE_BITS + CW;
    localparam int DW      = SQ_W + CW;
    localparam int QW      = SUM_W + FW;
    localparam int MW      = QW + wmsb_pkg::MARGIN_W;
    localparam int XW      = QW + 8;

    localparam logic [CW-1:0]        WIN_CAP  = CW'(CAP);
    localparam logic [CW-1:0]        WIN_RST  = CW'(wmsb_pkg::WIN_RESET);
    localparam logic signed [XW-1:0] MEAN_LIM = XW'(wmsb_pkg::MEAN_MAX);
    localparam logic signed [XW-1:0] HIGH_LIM = XW'(wmsb_pkg::HIGH_MAX);
    localparam logic signed [XW-1:0] LOW_TOP  = XW'(wmsb_pkg::LOW_MAX);
    localparam logic signed [XW-1:0] LOW_BOT  = XW'(wmsb_pkg::LOW_MIN);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b000_0001,
        S_PREP   = 7'b000_0010,
        S_SQ     = 7'b000_0100,
        S_NMUL   = 7'b000_1000,
        S_ROOT   = 7'b001_0000,
        S_SIGMA  = 7'b010_0000,
        S_MARGIN = 7'b100_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     win_reg, win_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [CW-1:0]     filled_reg, filled_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic              full_reg, full_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers
    logic [SAMPLE_BITS-1:0]        samp_reg;
    logic [SAMPLE_BITS-1:0]        old_reg;
    logic [SAMPLE_BITS-1:0]        ring_rd_reg;
    logic [QW-1:0]                 mean_reg;
    logic [wmsb_pkg::MEAN_W-1:0]   mean_out_reg;
    logic [wmsb_pkg::BAND_W-1:0]   low_out_reg;
    logic [wmsb_pkg::BAND_W-1:0]   high_out_reg;
    logic [CW-1:0]                 used_out_reg;

    logic [SAMPLE_BITS-1:0] ring_mem [DEPTH];

    logic              item_ok;
    logic              cfg_ok;
    logic [CW-1:0]     w_eff;
    logic [CW-1:0]     slot_a;
    logic [CW-1:0]     slot_b;
    logic [CW-1:0]     fill_a;
    logic              full_a;
    logic              ring_we;

    logic [SAMPLE_BITS-1:0] old_x;
    logic [SUM_W-1:0]       sum_upd;
    logic [SQ_W-1:0]        sq_upd;
    logic [DW-1:0]          d_val;

    logic              start_sq, start_nm, start_root, start_sig, start_mg;
    logic              load_out;

    logic                     sqn_busy, sqo_busy, ss_busy, nm_busy;
    logic                     rt_busy, dv_busy, mg_busy;
    logic [2*SAMPLE_BITS-1:0] sqn_p, sqo_p;
    logic [2*SUM_W-1:0]       ss_p;
    logic [DW-1:0]            nm_p;
    logic [QW-1:0]            rt_root;
    logic [QW-1:0]            dv_q;
    logic [QW-1:0]            dv_num;
    logic [MW-1:0]            mg_num;
    logic [MW-1:0]            mg_q;

    logic signed [XW-1:0] mean_x, margin_x, high_x, low_x;
    logic [wmsb_pkg::MEAN_W-1:0] mean_sat;
    logic [wmsb_pkg::BAND_W-1:0] high_sat;
    logic [wmsb_pkg::BAND_W-1:0] low_sat;

    assign item_ok = item.valid && item.ready;
    assign cfg_ok  = cfg.valid && cfg.ready;

    // slot and fill decisions for an incoming sample
    always_comb
    begin
        if (win_reg == '0)
            w_eff = CW'(1);
        else if (win_reg > WIN_CAP)
            w_eff = WIN_CAP;
        else
            w_eff = win_reg;

        slot_a = item.restart ? '0 : CW'(slot_reg);
        if (slot_a >= w_eff)
            slot_a = '0;
        fill_a = item.restart ? '0 : filled_reg;
        full_a = (fill_a >= w_eff);
        slot_b = slot_a + CW'(1);
        if (slot_b >= w_eff)
            slot_b = '0;
    end

    assign ring_we = item_ok;

    // sum updates and the difference n*sumsq - sum^2
    always_comb
    begin
        old_x   = full_reg ? ring_rd_reg : '0;
        sum_upd = sum_reg - SUM_W'(old_reg) + SUM_W'(samp_reg);
        sq_upd  = sq_reg - SQ_W'(sqo_p) + SQ_W'(sqn_p);
        d_val   = nm_p - DW'(ss_p);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        slot_next      = slot_reg;
        filled_next    = filled_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        start_sq       = 1'b0;
        start_nm       = 1'b0;
        start_root     = 1'b0;
        start_sig      = 1'b0;
        start_mg       = 1'b0;
        load_out       = 1'b0;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_ok)
                begin
                    slot_next   = AW'(slot_b);
                    filled_next = full_a ? fill_a : fill_a + CW'(1);
                    full_next   = full_a;
                    if (item.restart)
                    begin
                        sum_next = '0;
                        sq_next  = '0;
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_SQ;
            end
            S_SQ:
            begin
                if (!sqn_busy && !sqo_busy)
                begin
                    // squares of new and evicted samples are ready
                    sum_next   = sum_upd;
                    sq_next    = sq_upd;
                    start_nm   = 1'b1;
                    state_next = S_NMUL;
                end
            end
            S_NMUL:
            begin
                if (!nm_busy && !ss_busy)
                begin
                    start_root = 1'b1;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (!rt_busy && !dv_busy)
                begin
                    start_sig  = 1'b1;
                    state_next = S_SIGMA;
                end
            end
            S_SIGMA:
            begin
                if (!dv_busy)
                begin
                    start_mg   = 1'b1;
                    state_next = S_MARGIN;
                end
            end
            S_MARGIN:
            begin
                if (!mg_busy && (!out_valid_reg || result.ready))
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // window write clears the history
        if (cfg_ok)
        begin
            win_next    = cfg.window_size;
            slot_next   = '0;
            filled_next = '0;
            sum_next    = '0;
            sq_next     = '0;
        end

        // squarers start after the evicted sample is read
        start_sq = (state_reg == S_PREP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= WIN_RST;
            slot_reg      <= '0;
            filled_reg    <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            slot_reg      <= slot_next;
            filled_reg    <= filled_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sample ring, read before write at the same slot
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_rd_reg               <= ring_mem[AW'(slot_a)];
            ring_mem[AW'(slot_a)]     <= item.sample;
        end
    end

    // sample payload
    always_ff @(posedge clk)
    begin
        if (item_ok)
            samp_reg <= item.sample;
        if (state_reg == S_PREP)
            old_reg <= old_x;
        if (start_sig)
            mean_reg <= dv_q;
    end

    // square of the new and evicted sample
    wmsb_smul #(.AW(SAMPLE_BITS), .BW(SAMPLE_BITS)) u_sq_new (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_sq),
        .a       (samp_reg),
        .b       (samp_reg),
        .busy    (sqn_busy),
        .product (sqn_p)
    );

    wmsb_smul #(.AW(SAMPLE_BITS), .BW(SAMPLE_BITS)) u_sq_old (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_sq),
        .a       (old_x),
        .b       (old_x),
        .busy    (sqo_busy),
        .product (sqo_p)
    );

    // square of the running sum, started as soon as the sum is known
    wmsb_smul #(.AW(SUM_W), .BW(SUM_W)) u_sum_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_sq),
        .a       (sum_reg - SUM_W'(old_x) + SUM_W'(samp_reg)),
        .b       (sum_reg - SUM_W'(old_x) + SUM_W'(samp_reg)),
        .busy    (ss_busy),
        .product (ss_p)
    );

    // n times the running square sum
    wmsb_smul #(.AW(SQ_W), .BW(CW)) u_n_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_nm),
        .a       (sq_upd),
        .b       (filled_reg),
        .busy    (nm_busy),
        .product (nm_p)
    );

    // root of (n*sumsq - sum^2) in Q.8
    wmsb_sqrt #(.RW(QW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_root),
        .radicand ({d_val, {(2*FW){1'b0}}}),
        .busy     (rt_busy),
        .root     (rt_root)
    );

    // shared divide by n: mean first, then sigma
    assign dv_num = start_sig ? rt_root : {sum_reg, {FW{1'b0}}};

    wmsb_sdiv #(.NW(QW), .DW(CW)) u_div_n (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_root || start_sig),
        .dividend (dv_num),
        .divisor  (filled_reg),
        .busy     (dv_busy),
        .quotient (dv_q)
    );

    // margin = sigma * 49 / 25
    assign mg_num = MW'(dv_q) * MW'(wmsb_pkg::MARGIN_NUM);

    wmsb_sdiv #(.NW(MW), .DW(CW)) u_div_25 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_mg),
        .dividend (mg_num),
        .divisor  (CW'(wmsb_pkg::MARGIN_DEN)),
        .busy     (mg_busy),
        .quotient (mg_q)
    );

    // band edges and saturation
    always_comb
    begin
        mean_x   = XW'(mean_reg);
        margin_x = XW'(mg_q);
        high_x   = mean_x + margin_x;
        low_x    = mean_x - margin_x;

        mean_sat = (mean_x > MEAN_LIM) ? wmsb_pkg::MEAN_W'(MEAN_LIM)
                                       : wmsb_pkg::MEAN_W'(mean_x);
        high_sat = (high_x > HIGH_LIM) ? wmsb_pkg::BAND_W'(HIGH_LIM)
                                       : wmsb_pkg::BAND_W'(high_x);
        if (low_x > LOW_TOP)
            low_sat = wmsb_pkg::BAND_W'(LOW_TOP);
        else if (low_x < LOW_BOT)
            low_sat = wmsb_pkg::BAND_W'(LOW_BOT);
        else
            low_sat = wmsb_pkg::BAND_W'(low_x);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            mean_out_reg <= mean_sat;
            low_out_reg  <= low_sat;
            high_out_reg <= high_sat;
            used_out_reg <= filled_reg;
        end
    end

    assign item.ready          = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.window_mean  = mean_out_reg;
    assign result.band_low     = low_out_reg;
    assign result.band_high    = high_out_reg;
    assign result.samples_used = used_out_reg;

endmodule

`default_nettype wire

// ----- bench/window_mean_stddev_band_test.sv -----
// self-checking bench for the windowed mean / stddev band block
// depends on wmsb_pkg, the channel interfaces in wmsb_if and the window_mean_stddev_band rtl
// a directed table runs first, then random sample requests under four idle and stall phases
`default_nettype none

module window_mean_stddev_band_test;

    timeunit 1ns;
    timeprecision 1ps;

    import wmsb_pkg::*;

    localparam int  CLK_PERIOD     = 8;
    localparam int  RESET_CYCLES   = 9;
    localparam int  SAMPLE_W       = DEF_SAMPLE_BITS;
    localparam int  RING_DEPTH     = DEF_MAX_WINDOW;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  TAIL_CYCLES    = 160;
    localparam int  PHASE_ITEMS    = 265;
    localparam int  REPORT_LIMIT   = 10;

    // one result request, field by field
    typedef struct packed {
        logic [MEAN_W-1:0]        mean;
        logic signed [BAND_W-1:0] low;
        logic [BAND_W-1:0]        high;
        logic [CNT_W-1:0]         used;
    } band_t;

    typedef enum logic { ROW_SAMPLE, ROW_WINDOW } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic [SAMPLE_W-1:0] value;
        logic                restart;
        bit                  typed;
        band_t               want;
    } row_t;

    localparam band_t NO_BAND = '0;

    logic clk = 1'b0;
    logic rst_n;

    wmsb_sample_if #(.SAMPLE_BITS(SAMPLE_W)) item_ch ();
    wmsb_result_if                           res_ch ();
    wmsb_cfg_if                              cfg_ch ();

    window_mean_stddev_band #(
        .MAX_WINDOW  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predictor state: window register, sample ring and running sums
    logic [CNT_W-1:0]    window_reg = CNT_W'(WIN_RESET);
    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [5:0]          ring_slot = '0;
    logic [CNT_W-1:0]    ring_fill = '0;
    logic [21:0]         win_sum   = '0;
    logic [37:0]         win_sqsum = '0;

    band_t expected_bands [$];
    int    fail_count     = 0;
    int    idle_cycles    = 0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;

    // typed expectation travels with the sample request
    bit    typed_use;
    band_t typed_band;

    // directed table: extremes, single sample, window 0 and above 64, restart with write
    row_t directed_rows [18] = '{
        '{ROW_SAMPLE, 16'd0,     1'b0, 1'b1, '{24'd0, 25'sd0, 25'd0, 7'd1}},
        '{ROW_SAMPLE, 16'd65535, 1'b0, 1'b0, NO_BAND},
        '{ROW_SAMPLE, 16'd65535, 1'b1, 1'b1,
          '{24'd16776960, 25'sd16776960, 25'd16776960, 7'd1}},
        '{ROW_SAMPLE, 16'd0,     1'b0, 1'b0, NO_BAND},
        '{ROW_WINDOW, 16'd0,     1'b0, 1'b0, NO_BAND},
        '{ROW_SAMPLE, 16'd12345, 1'b0, 1'b1,
          '{24'd3160320, 25'sd3160320, 25'd3160320, 7'd1}},
        '{ROW_SAMPLE, 16'd54321, 1'b0, 1'b1,
          '{24'd13906176, 25'sd13906176, 25'd13906176, 7'd1}},
        '{ROW_WINDOW, 16'd127,   1'b0, 1'b0, NO_BAND},
        '{ROW_SAMPLE, 16'd65535, 1'b0, 1'b0, NO_BAND},
        '{ROW_SAMPLE, 16'd0,     1'b0, 1'b0, NO_BAND},
        '{ROW_SAMPLE, 16'd40000, 1'b0, 1'b0, NO_BAND},
        '{ROW_WINDOW, 16'd2,     1'b0, 1'b0, NO_BAND},
        '{ROW_SAMPLE, 16'd65535, 1'b0, 1'b0, NO_BAND},
        '{ROW_SAMPLE, 16'd0,     1'b0, 1'b0, NO_BAND},
        '{ROW_SAMPLE, 16'd65535, 1'b0, 1'b0, NO_BAND},
        '{ROW_WINDOW, 16'd64,    1'b0, 1'b0, NO_BAND},
        '{ROW_SAMPLE, 16'd256,   1'b1, 1'b1, '{24'd65536, 25'sd65536, 25'd65536, 7'd1}},
        '{ROW_SAMPLE, 16'd1,     1'b0, 1'b0, NO_BAND}
    };

    function automatic void clear_window();
        ring_slot = '0;
        ring_fill = '0;
        win_sum   = '0;
        win_sqsum = '0;
    endfunction

    // take one sample into the window and work out its mean and band
    function automatic band_t next_band(input logic [SAMPLE_W-1:0] value, input logic rs);
        int unsigned   w;
        logic [63:0]   n, mean, d, root, trial, sigma, margin, upper;
        longint        lower;
        band_t         b;

        w = (window_reg == 0) ? 1 : ((window_reg > RING_DEPTH) ? RING_DEPTH : window_reg);
        if (rs)
            clear_window();
        if (ring_slot >= w)
            ring_slot = '0;

        // evict the oldest sample once the window is full
        if (ring_fill >= w)
        begin
            win_sum   = win_sum - ring_mem[ring_slot];
            win_sqsum = win_sqsum
                        - 38'(64'(ring_mem[ring_slot]) * 64'(ring_mem[ring_slot]));
        end
        else
        begin
            ring_fill = ring_fill + 1'b1;
        end
        ring_mem[ring_slot] = value;
        win_sum   = win_sum + value;
        win_sqsum = win_sqsum + 38'(64'(value) * 64'(value));
        ring_slot = ring_slot + 1'b1;
        if (ring_slot >= w)
            ring_slot = '0;

        n    = 64'(ring_fill);
        mean = (64'(win_sum) << FRAC_W) / n;

        // n^2 * variance, scaled by 2^16 so the root lands in q.8
        d = (n * 64'(win_sqsum) - 64'(win_sum) * 64'(win_sum)) << (2 * FRAC_W);
        root = '0;
        for (int k = 31; k >= 0; k--)
        begin
            trial = root | (64'd1 << k);
            if (trial * trial <= d)
                root = trial;
        end
        sigma  = root / n;
        margin = (sigma * 64'(MARGIN_NUM)) / 64'(MARGIN_DEN);

        upper = mean + margin;
        if (upper > 64'(HIGH_MAX))
            upper = 64'(HIGH_MAX);
        lower = longint'(mean) - longint'(margin);
        if (lower > longint'(LOW_MAX))
            lower = longint'(LOW_MAX);
        if (lower < longint'(LOW_MIN))
            lower = longint'(LOW_MIN);
        if (mean > 64'(MEAN_MAX))
            mean = 64'(MEAN_MAX);

        b.mean = mean[MEAN_W-1:0];
        b.low  = lower[BAND_W-1:0];
        b.high = upper[BAND_W-1:0];
        b.used = n[CNT_W-1:0];
        return b;
    endfunction

    function automatic void report_fail(input string what, input band_t want, input band_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t %s: expected mean %0d low %0d high %0d used %0d",
                     $time, what, want.mean, want.low, want.high, want.used,
                     " / got mean %0d low %0d high %0d used %0d",
                     got.mean, got.low, got.high, got.used);
    endfunction

    // receiver: random stalls by phase
    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // monitor: check results, track window writes, predict accepted samples
    always @(posedge clk)
    begin
        band_t got;
        band_t want;
        band_t pred;
        bit    moved;

        moved = 1'b0;
        if (rst_n)
        begin
            // results first so a request taken at this edge is not matched
            if (res_ch.valid && res_ch.ready)
            begin
                moved    = 1'b1;
                got.mean = res_ch.window_mean;
                got.low  = res_ch.band_low;
                got.high = res_ch.band_high;
                got.used = res_ch.samples_used;
                if (expected_bands.size() == 0)
                    report_fail("unexpected result", NO_BAND, got);
                else
                begin
                    want = expected_bands.pop_front();
                    if (got.mean !== want.mean || got.low !== want.low ||
                        got.high !== want.high || got.used !== want.used)
                        report_fail("result mismatch", want, got);
                end
            end

            if (cfg_ch.valid && cfg_ch.ready)
            begin
                moved      = 1'b1;
                window_reg = cfg_ch.window_size;
                clear_window();
            end

            if (item_ch.valid && item_ch.ready)
            begin
                moved = 1'b1;
                pred  = next_band(item_ch.sample, item_ch.restart);
                expected_bands = {expected_bands, (typed_use ? typed_band : pred)};
            end
        end

        // watchdog on cycles without any accepted request
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // sender: optional gap, then hold the request until it is taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic rs,
                               input bit typed, input band_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.sample  <= value;
        item_ch.restart <= rs;
        typed_use       <= typed;
        typed_band      <= want;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_bands.size() != 0);
    endtask

    // window write only while the block is idle
    task automatic write_window(input logic [CNT_W-1:0] value);
        drain_results();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [SAMPLE_W-1:0] s;
        logic [SAMPLE_W-1:0] base;
        logic [CNT_W-1:0]    win;
        int                  seg;
        int                  sent;

        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.sample     = '0;
        item_ch.restart    = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.window_size = CNT_W'(WIN_RESET);
        typed_use          = 1'b0;
        typed_band         = NO_BAND;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WINDOW)
                write_window(directed_rows[i].value[CNT_W-1:0]);
            else
                send_sample(directed_rows[i].value, directed_rows[i].restart,
                            directed_rows[i].typed, directed_rows[i].want);
        end

        // random segments, each after a window write
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                case ($urandom_range(4))
                    0: win = CNT_W'($urandom_range(1, 4));
                    1: win = CNT_W'($urandom_range(5, 63));
                    2: win = CNT_W'(RING_DEPTH);
                    3: win = CNT_W'($urandom_range(65, 127));
                    default: win = $urandom_range(1) ? 7'd127 : 7'd0;
                endcase
                write_window(win);
                base = SAMPLE_W'($urandom);
                seg  = $urandom_range(16, 140);
                for (int k = 0; k < seg; k++)
                begin
                    // full range, clustered, near the extremes, single bit flips
                    case ($urandom_range(3))
                        0: s = SAMPLE_W'($urandom);
                        1: s = base + SAMPLE_W'($urandom_range(0, 31));
                        2: s = $urandom_range(1) ? 16'hFFFF - 16'($urandom_range(0, 7))
                                                 : 16'($urandom_range(0, 7));
                        default: s = base ^ (16'h1 << $urandom_range(15));
                    endcase
                    send_sample(s, ($urandom_range(99) < 3), 1'b0, NO_BAND);
                end
                sent += seg;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_bands.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/wmsb_pkg.sv
rtl/wmsb_if.sv
rtl/wmsb_smul.sv
rtl/wmsb_sdiv.sv
rtl/wmsb_sqrt.sv
rtl/window_mean_stddev_band.sv
bench/window_mean_stddev_band_test.sv
